@@ src/mctdp_pkg.sv @@
// ----------------------------------------------------------------------------
// mctdp_pkg
// Shared types and constants of the least-cost trip planner.
// ----------------------------------------------------------------------------
package mctdp_pkg;

  localparam int NUM_CITIES = 64;
  localparam int CITY_W     = $clog2(NUM_CITIES);
  localparam int FARE_W     = 12;
  localparam int COST_W     = 16;
  localparam int SUM_W      = COST_W + 1;
  localparam int CMD_W      = 2;
  localparam int IN_DATA_W  = 32;

  localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

  typedef enum logic [CMD_W-1:0] {
    CMD_FARE  = 2'd0,
    CMD_HOTEL = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_t;

endpackage

@@ src/mctdp_ram.sv @@
// ----------------------------------------------------------------------------
// mctdp_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mctdp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/min_cost_trip_dp_top.sv @@
// ----------------------------------------------------------------------------
// min_cost_trip_dp_top
// Least-cost trip planner: table loads and cost queries over a line of cities.
// ----------------------------------------------------------------------------
// Table writes give no result.
// A query from s to d runs, for each j in s+1..d, one row pass over s..j-1
// and a drain step; one fare, hotel and row read per cycle in each pass.
// One request at a time; the result register frees the input side unless an
// earlier result is still held there, which holds the finished query back.
// rst_n (synchronous) clears control state; table contents stay undefined.
// ----------------------------------------------------------------------------
module min_cost_trip_dp_top
  import mctdp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // entry_index[5:0], entry_value[17:6], start_city[23:18], dest_city[29:24]
  input  logic [IN_DATA_W-1:0] in_tdata,
  // command[1:0]
  input  logic [CMD_W-1:0]     in_tuser,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // min_cost[15:0]
  output logic [COST_W-1:0]    out_tdata,
  // no_route[0], saturated[1]
  output logic [1:0]           out_tuser
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN,
    S_DONE
  } state_t;

  state_t              state_r;
  logic [CITY_W-1:0]   j_r, idx_r, start_r, dest_r;
  logic [COST_W-1:0]   least_r, res_cost_r;
  logic                res_nr_r, sat_r, rd_vld_r;
  logic                out_valid_r;
  logic [COST_W-1:0]   out_cost_r;
  logic                out_nr_r, out_sat_r;

  logic [CITY_W-1:0]   entry_index, start_city, dest_city;
  logic [FARE_W-1:0]   entry_value;
  cmd_t                command;
  logic                accept;

  logic [FARE_W-1:0]   fare_rd, hotel_rd;
  logic [COST_W-1:0]   best_rd;
  logic [CITY_W-1:0]   fare_raddr;
  logic [SUM_W-1:0]    sum;
  logic [COST_W-1:0]   cand, least_nxt;
  logic                cand_sat;
  logic                best_we;
  logic [CITY_W-1:0]   best_waddr;
  logic [COST_W-1:0]   best_wdata;

  assign entry_index = in_tdata[CITY_W-1:0];
  assign entry_value = in_tdata[CITY_W+FARE_W-1:CITY_W];
  assign start_city  = in_tdata[2*CITY_W+FARE_W-1:CITY_W+FARE_W];
  assign dest_city   = in_tdata[3*CITY_W+FARE_W-1:2*CITY_W+FARE_W];
  assign command     = cmd_t'(in_tuser);

  assign in_tready  = (state_r == S_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign fare_raddr = j_r - CITY_W'(1) - idx_r;

  assign sum      = SUM_W'(best_rd) + SUM_W'(hotel_rd) + SUM_W'(fare_rd);
  assign cand_sat = (sum >= SUM_W'(COST_MAX));
  assign cand     = cand_sat ? COST_MAX : sum[COST_W-1:0];
  assign least_nxt = (rd_vld_r && (cand < least_r)) ? cand : least_r;

  always_comb begin
    best_we    = 1'b0;
    best_waddr = j_r;
    best_wdata = least_nxt;
    if (accept && (command == CMD_QUERY)) begin
      best_we    = 1'b1;
      best_waddr = start_city;
      best_wdata = '0;
    end else if (state_r == S_DRAIN) begin
      best_we = 1'b1;
    end
  end

  mctdp_ram #(.WIDTH(FARE_W), .DEPTH(NUM_CITIES)) u_fare_ram (
    .clk   (clk),
    .we    (accept && (command == CMD_FARE)),
    .waddr (entry_index),
    .wdata (entry_value),
    .raddr (fare_raddr),
    .rdata (fare_rd)
  );

  mctdp_ram #(.WIDTH(FARE_W), .DEPTH(NUM_CITIES)) u_hotel_ram (
    .clk   (clk),
    .we    (accept && (command == CMD_HOTEL)),
    .waddr (entry_index),
    .wdata (entry_value),
    .raddr (idx_r),
    .rdata (hotel_rd)
  );

  mctdp_ram #(.WIDTH(COST_W), .DEPTH(NUM_CITIES)) u_best_ram (
    .clk   (clk),
    .we    (best_we),
    .waddr (best_waddr),
    .wdata (best_wdata),
    .raddr (idx_r),
    .rdata (best_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      if (rd_vld_r) begin
        if (cand_sat) begin
          sat_r <= 1'b1;
        end
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept && (command == CMD_QUERY)) begin
            start_r  <= start_city;
            dest_r   <= dest_city;
            j_r      <= start_city + CITY_W'(1);
            idx_r    <= start_city;
            least_r  <= COST_MAX;
            sat_r    <= 1'b0;
            res_nr_r <= 1'b0;
            rd_vld_r <= 1'b0;
            if (dest_city < start_city) begin
              res_cost_r <= COST_MAX;
              res_nr_r   <= 1'b1;
              state_r    <= S_DONE;
            end else if (dest_city == start_city) begin
              res_cost_r <= '0;
              state_r    <= S_DONE;
            end else begin
              state_r <= S_RUN;
            end
          end
        end
        S_RUN: begin
          rd_vld_r <= 1'b1;
          least_r  <= least_nxt;
          if (idx_r == j_r - CITY_W'(1)) begin
            state_r <= S_DRAIN;
          end else begin
            idx_r <= idx_r + CITY_W'(1);
          end
        end
        S_DRAIN: begin
          rd_vld_r <= 1'b0;
          least_r  <= COST_MAX;
          if (j_r == dest_r) begin
            res_cost_r <= least_nxt;
            state_r    <= S_DONE;
          end else begin
            j_r     <= j_r + CITY_W'(1);
            idx_r   <= start_r;
            state_r <= S_RUN;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_cost_r  <= res_cost_r;
            out_nr_r    <= res_nr_r;
            out_sat_r   <= sat_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_cost_r;
  assign out_tuser  = {out_sat_r, out_nr_r};

endmodule
